FILE: design/dda_line_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// dda line rasterizer assertion macros
// shared concurrent assertion forms on i_clk with synchronous reset
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define DDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda line rasterizer package
// widths, word types and opcodes shared by the rasterizer and its divider
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 20;
    localparam int COLOUR_BITS = 4;
    localparam int ACC_BITS    = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_BITS    = FRAC_BITS + 2;
    localparam int QUOT_BITS   = FRAC_BITS + 1;
    localparam int DIVD_BITS   = COORD_BITS + FRAC_BITS;
    localparam int LEFT_BITS   = COORD_BITS + 1;
    localparam int CNT_BITS    = $clog2(DIVD_BITS + 1);

    typedef enum logic [0:0] {
        OPC_START = 1'b0,
        OPC_STEP  = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                opcode;
        logic [COORD_BITS-1:0]  x_start;
        logic [COORD_BITS-1:0]  y_start;
        logic [COORD_BITS-1:0]  x_end;
        logic [COORD_BITS-1:0]  y_end;
        logic [COLOUR_BITS-1:0] colour_in;
    } t_in_word;

    typedef struct packed {
        logic [COORD_BITS-1:0]  pixel_x;
        logic [COORD_BITS-1:0]  pixel_y;
        logic [COLOUR_BITS-1:0] pixel_colour;
        logic                   last_pixel;
    } t_out_word;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

FILE: design/dda_divider.sv
// ----------------------------------------------------------------------------
// dda serial divider
// restoring shift-subtract divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dda_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [dda_pkg::DIVD_BITS-1:0]       i_dividend,
    input  logic [dda_pkg::COORD_BITS-1:0]      i_divisor,
    output dda_pkg::t_div_status                o_status,
    output logic [dda_pkg::QUOT_BITS-1:0]       o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic [dda_pkg::CNT_BITS-1:0]       r_count;
    logic [dda_pkg::DIVD_BITS-1:0]      r_quot;
    logic [dda_pkg::COORD_BITS-1:0]     r_rem;
    logic [dda_pkg::COORD_BITS-1:0]     r_divisor;

    logic [dda_pkg::COORD_BITS:0]       trial;
    logic [dda_pkg::COORD_BITS:0]       diff;
    logic                               ge;

    // partial remainder stays below the divisor, so it fits in COORD_BITS
    assign trial = {r_rem, r_quot[dda_pkg::DIVD_BITS-1]};
    assign diff  = trial - {1'b0, r_divisor};
    assign ge    = (trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= dda_pkg::CNT_BITS'(dda_pkg::DIVD_BITS);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == dda_pkg::CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[dda_pkg::DIVD_BITS-2:0], ge};
            r_rem  <= ge ? diff[dda_pkg::COORD_BITS-1:0] : trial[dda_pkg::COORD_BITS-1:0];
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    // quotient never exceeds 2^FRAC_BITS because |d| <= steps
    assign o_quotient    = r_quot[dda_pkg::QUOT_BITS-1:0];

endmodule

FILE: design/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda line rasterizer
// digital differential analyzer that turns two endpoints into a pixel stream
// ----------------------------------------------------------------------------
// A start word (opcode 0) brings two endpoints and a colour. Its first pixel,
// the start point, is issued at once; the block then computes the x and y
// increments with one shared serial divider, x first then y, and holds ready
// low until both are done. The divider gives one quotient bit per cycle. A
// zero-length line gives a single pixel marked last. Step words (opcode 1)
// then each give the next pixel, so a pixel writer can be fed one pixel per
// cycle while it keeps i_ready high; the final pixel of steps+1 carries
// last_pixel. A step with no line in progress gives no pixel. A start while
// a line is in progress drops the old line. Coordinates are the fixed-point
// accumulators rounded half up.
// ----------------------------------------------------------------------------
module dda_line_rasterizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dda_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output dda_pkg::t_out_word o_data
);

`include "dda_line_rasterizer_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_START_X,
        S_WAIT_X,
        S_START_Y,
        S_WAIT_Y
    } t_state;

    localparam logic [dda_pkg::ACC_BITS-1:0] HALF =
        dda_pkg::ACC_BITS'(1) << (dda_pkg::FRAC_BITS - 1);

    // sequencer and line state
    t_state                              r_state;
    logic [dda_pkg::ACC_BITS-1:0]        r_x_acc;
    logic [dda_pkg::ACC_BITS-1:0]        r_y_acc;
    logic [dda_pkg::INC_BITS-1:0]        r_x_inc;
    logic [dda_pkg::INC_BITS-1:0]        r_y_inc;
    logic [dda_pkg::LEFT_BITS-1:0]       r_pixels_left;
    logic [dda_pkg::COLOUR_BITS-1:0]     r_colour;
    logic                                r_line_active;
    logic [dda_pkg::COORD_BITS-1:0]      r_adx;
    logic [dda_pkg::COORD_BITS-1:0]      r_ady;
    logic                                r_x_neg;
    logic                                r_y_neg;

    // output register
    logic                                r_out_valid;
    dda_pkg::t_out_word                  r_out;

    // start word decode
    logic                                in_accept;
    logic                                x_neg;
    logic                                y_neg;
    logic [dda_pkg::COORD_BITS-1:0]      adx;
    logic [dda_pkg::COORD_BITS-1:0]      ady;
    logic [dda_pkg::COORD_BITS-1:0]      steps;

    // step word datapath
    logic [dda_pkg::ACC_BITS-1:0]        n_x_acc;
    logic [dda_pkg::ACC_BITS-1:0]        n_y_acc;
    logic [dda_pkg::LEFT_BITS-1:0]       n_pixels_left;
    logic [dda_pkg::ACC_BITS-1:0]        x_round;
    logic [dda_pkg::ACC_BITS-1:0]        y_round;

    // divider hookup
    logic                                div_start;
    logic [dda_pkg::DIVD_BITS-1:0]       div_dividend;
    dda_pkg::t_div_status                div_status;
    logic [dda_pkg::QUOT_BITS-1:0]       div_quot;
    logic [dda_pkg::INC_BITS-1:0]        quot_ext;

    // a new word is taken only while no division runs and when the output slot frees up
    assign o_ready   = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign in_accept = i_valid && o_ready;

    assign x_neg = (i_data.x_end < i_data.x_start);
    assign y_neg = (i_data.y_end < i_data.y_start);
    assign adx   = x_neg ? (i_data.x_start - i_data.x_end) : (i_data.x_end - i_data.x_start);
    assign ady   = y_neg ? (i_data.y_start - i_data.y_end) : (i_data.y_end - i_data.y_start);
    assign steps = (adx > ady) ? adx : ady;

    // increments are sign-extended onto the accumulator width
    assign n_x_acc = r_x_acc + {{(dda_pkg::ACC_BITS - dda_pkg::INC_BITS)
                                 {r_x_inc[dda_pkg::INC_BITS-1]}}, r_x_inc};
    assign n_y_acc = r_y_acc + {{(dda_pkg::ACC_BITS - dda_pkg::INC_BITS)
                                 {r_y_inc[dda_pkg::INC_BITS-1]}}, r_y_inc};
    assign n_pixels_left = r_pixels_left - 1'b1;

    // round half up
    assign x_round = n_x_acc + HALF;
    assign y_round = n_y_acc + HALF;

    // divisor is steps, which the pixel counter holds while dividing
    assign div_start    = (r_state == S_START_X) || (r_state == S_START_Y);
    assign div_dividend = (r_state == S_START_X)
                        ? {r_adx, {dda_pkg::FRAC_BITS{1'b0}}}
                        : {r_ady, {dda_pkg::FRAC_BITS{1'b0}}};
    assign quot_ext     = {1'b0, div_quot};

    dda_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_pixels_left[dda_pkg::COORD_BITS-1:0]),
        .o_status   (div_status),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_x_acc       <= '0;
            r_y_acc       <= '0;
            r_x_inc       <= '0;
            r_y_inc       <= '0;
            r_pixels_left <= '0;
            r_colour      <= '0;
            r_line_active <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // output word drains when taken
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        unique case (i_data.opcode)
                            dda_pkg::OPC_START: begin
                                r_colour          <= i_data.colour_in;
                                r_x_acc           <= {1'b0, i_data.x_start,
                                                      {dda_pkg::FRAC_BITS{1'b0}}};
                                r_y_acc           <= {1'b0, i_data.y_start,
                                                      {dda_pkg::FRAC_BITS{1'b0}}};
                                r_x_inc           <= '0;
                                r_y_inc           <= '0;
                                r_pixels_left     <= {1'b0, steps};
                                r_adx             <= adx;
                                r_ady             <= ady;
                                r_x_neg           <= x_neg;
                                r_y_neg           <= y_neg;
                                r_out_valid       <= 1'b1;
                                r_out.pixel_x     <= i_data.x_start;
                                r_out.pixel_y     <= i_data.y_start;
                                r_out.pixel_colour <= i_data.colour_in;
                                // zero-length line is a single last pixel
                                if (steps == '0) begin
                                    r_line_active    <= 1'b0;
                                    r_out.last_pixel <= 1'b1;
                                end else begin
                                    r_line_active    <= 1'b1;
                                    r_out.last_pixel <= 1'b0;
                                    r_state          <= S_START_X;
                                end
                            end
                            dda_pkg::OPC_STEP: begin
                                if (!r_line_active || (r_pixels_left == '0)) begin
                                    r_line_active <= 1'b0;
                                end else begin
                                    r_x_acc            <= n_x_acc;
                                    r_y_acc            <= n_y_acc;
                                    r_pixels_left      <= n_pixels_left;
                                    r_line_active      <= (n_pixels_left != '0);
                                    r_out_valid        <= 1'b1;
                                    r_out.pixel_x      <= x_round[dda_pkg::FRAC_BITS +:
                                                                  dda_pkg::COORD_BITS];
                                    r_out.pixel_y      <= y_round[dda_pkg::FRAC_BITS +:
                                                                  dda_pkg::COORD_BITS];
                                    r_out.pixel_colour <= r_colour;
                                    r_out.last_pixel   <= (n_pixels_left == '0);
                                end
                            end
                            default: begin
                                r_line_active <= r_line_active;
                            end
                        endcase
                    end
                end
                S_START_X: begin
                    r_state <= S_WAIT_X;
                end
                S_WAIT_X: begin
                    if (div_status.done) begin
                        r_x_inc <= r_x_neg ? (-quot_ext) : quot_ext;
                        r_state <= S_START_Y;
                    end
                end
                S_START_Y: begin
                    r_state <= S_WAIT_Y;
                end
                S_WAIT_Y: begin
                    if (div_status.done) begin
                        r_y_inc <= r_y_neg ? (-quot_ext) : quot_ext;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // no word is taken while the increments are being divided
    `DDA_ASSERT_NOW(a_busy_not_ready, r_state != S_IDLE, !o_ready, "ready high while dividing")
    // an active line always has pixels left to give
    `DDA_ASSERT_NOW(a_active_has_left, r_line_active, r_pixels_left != '0, "active line with no pixels left")
    // divider finishes only while the sequencer waits for it
    `DDA_ASSERT_NOW(a_done_in_wait, div_status.done, (r_state == S_WAIT_X) || (r_state == S_WAIT_Y), "divider done outside wait")
    // the final step ends the line and issues a word
    `DDA_ASSERT_NEXT(a_last_step_ends, in_accept && (i_data.opcode == dda_pkg::OPC_STEP) && r_line_active && (r_pixels_left == dda_pkg::LEFT_BITS'(1)), !r_line_active && o_valid && o_data.last_pixel, "final step did not end line")

endmodule

FILE: tb/sv/dda_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda line rasterizer pixel checker
// follows every accepted input word, predicts the pixel it gives and compares
// each accepted output word, field by field, with the oldest prediction
// ----------------------------------------------------------------------------
module dda_line_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  dda_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  dda_pkg::t_out_word i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_pixel_count
);

    // predicted line state
    logic [dda_pkg::ACC_BITS-1:0]    x_acc;
    logic [dda_pkg::ACC_BITS-1:0]    y_acc;
    logic [dda_pkg::INC_BITS-1:0]    x_slope;
    logic [dda_pkg::INC_BITS-1:0]    y_slope;
    logic [dda_pkg::LEFT_BITS-1:0]   pixels_to_go;
    logic [dda_pkg::COLOUR_BITS-1:0] line_colour;
    logic                            drawing;

    dda_pkg::t_out_word predicted_pixels[$];
    int                 mismatches = 0;
    int                 checked    = 0;

    // accumulator rounded half up to a whole coordinate
    function automatic logic [dda_pkg::COORD_BITS-1:0] rounded(
        logic [dda_pkg::ACC_BITS-1:0] acc);
        logic [dda_pkg::ACC_BITS-1:0] biased;
        biased = acc + (dda_pkg::ACC_BITS'(1) << (dda_pkg::FRAC_BITS - 1));
        return biased[dda_pkg::FRAC_BITS +: dda_pkg::COORD_BITS];
    endfunction

    // signed per-step increment, magnitude truncated toward zero
    function automatic logic [dda_pkg::INC_BITS-1:0] slope(
        logic [dda_pkg::COORD_BITS-1:0] from,
        logic [dda_pkg::COORD_BITS-1:0] to,
        logic [dda_pkg::LEFT_BITS-1:0]  steps);
        logic [dda_pkg::DIVD_BITS-1:0] scaled;
        logic [dda_pkg::INC_BITS-1:0]  mag;
        scaled = dda_pkg::DIVD_BITS'(to >= from ? to - from : from - to) << dda_pkg::FRAC_BITS;
        mag    = dda_pkg::INC_BITS'(scaled / dda_pkg::DIVD_BITS'(steps));
        return (to < from) ? -mag : mag;
    endfunction

    function automatic dda_pkg::t_out_word pixel_here(logic last);
        dda_pkg::t_out_word p;
        p.pixel_x      = rounded(x_acc);
        p.pixel_y      = rounded(y_acc);
        p.pixel_colour = line_colour;
        p.last_pixel   = last;
        return p;
    endfunction

    function automatic void take_word(dda_pkg::t_in_word w);
        logic [dda_pkg::COORD_BITS-1:0] dx;
        logic [dda_pkg::COORD_BITS-1:0] dy;
        logic [dda_pkg::LEFT_BITS-1:0]  steps;
        if (w.opcode == dda_pkg::OPC_START) begin
            dx          = w.x_end >= w.x_start ? w.x_end - w.x_start : w.x_start - w.x_end;
            dy          = w.y_end >= w.y_start ? w.y_end - w.y_start : w.y_start - w.y_end;
            steps       = (dx > dy) ? dda_pkg::LEFT_BITS'(dx) : dda_pkg::LEFT_BITS'(dy);
            line_colour = w.colour_in;
            x_acc       = dda_pkg::ACC_BITS'(w.x_start) << dda_pkg::FRAC_BITS;
            y_acc       = dda_pkg::ACC_BITS'(w.y_start) << dda_pkg::FRAC_BITS;
            if (steps == '0) begin
                // zero-length line: one pixel, marked last
                x_slope      = '0;
                y_slope      = '0;
                pixels_to_go = '0;
                drawing      = 1'b0;
                predicted_pixels.push_back(pixel_here(1'b1));
            end else begin
                x_slope      = slope(w.x_start, w.x_end, steps);
                y_slope      = slope(w.y_start, w.y_end, steps);
                pixels_to_go = steps;
                drawing      = 1'b1;
                predicted_pixels.push_back(pixel_here(1'b0));
            end
        end else if (drawing && pixels_to_go != '0) begin
            x_acc        = x_acc + {{(dda_pkg::ACC_BITS-dda_pkg::INC_BITS)
                                     {x_slope[dda_pkg::INC_BITS-1]}}, x_slope};
            y_acc        = y_acc + {{(dda_pkg::ACC_BITS-dda_pkg::INC_BITS)
                                     {y_slope[dda_pkg::INC_BITS-1]}}, y_slope};
            pixels_to_go = pixels_to_go - 1'b1;
            drawing      = (pixels_to_go != '0);
            predicted_pixels.push_back(pixel_here(pixels_to_go == '0));
        end else begin
            // step with no line in progress
            drawing = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] pixel %0d mismatch: %s", $time, checked, what);
    endtask

    always @(posedge i_clk) begin : watch
        dda_pkg::t_out_word want;
        if (!i_rst_n) begin
            x_acc        = '0;
            y_acc        = '0;
            x_slope      = '0;
            y_slope      = '0;
            pixels_to_go = '0;
            line_colour  = '0;
            drawing      = 1'b0;
            predicted_pixels.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                take_word(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (predicted_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected word x=%0d y=%0d", i_out_data.pixel_x,
                                              i_out_data.pixel_y));
                end else begin
                    want = predicted_pixels.pop_front();
                    if (i_out_data.pixel_x !== want.pixel_x) begin
                        report_mismatch($sformatf("pixel_x got %0d want %0d",
                                                  i_out_data.pixel_x, want.pixel_x));
                    end
                    if (i_out_data.pixel_y !== want.pixel_y) begin
                        report_mismatch($sformatf("pixel_y got %0d want %0d",
                                                  i_out_data.pixel_y, want.pixel_y));
                    end
                    if (i_out_data.pixel_colour !== want.pixel_colour) begin
                        report_mismatch($sformatf("pixel_colour got %0d want %0d",
                                                  i_out_data.pixel_colour, want.pixel_colour));
                    end
                    if (i_out_data.last_pixel !== want.last_pixel) begin
                        report_mismatch($sformatf("last_pixel got %0b want %0b",
                                                  i_out_data.last_pixel, want.last_pixel));
                    end
                end
            end
        end
        o_fail_count  <= mismatches;
        o_pending     <= predicted_pixels.size();
        o_pixel_count <= checked;
    end

endmodule

FILE: tb/sv/dda_line_rasterizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda line rasterizer test
// drives start and step words into the rasterizer with random gaps and
// output stalls; a checker beside the block predicts and compares each pixel
// ----------------------------------------------------------------------------
module dda_line_rasterizer_test;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int COORD_MAX     = (1 << dda_pkg::COORD_BITS) - 1;
    localparam int RANDOM_WORDS  = 1600;
    localparam int MAX_GAP       = 17;
    localparam int HOLD_CYCLES   = 400;
    localparam int PRESSURE_LEN  = 300;
    // a start word keeps the divider busy with no pixel due
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int LIMIT_CYCLES  = 1500000;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_ready = 1'b0;
    dda_pkg::t_in_word  i_data  = '0;
    logic               o_ready;
    logic               o_valid;
    dda_pkg::t_out_word o_data;

    int fail_total;
    int pixels_pending;
    int pixels_checked;

    // stimulus bookkeeping, also used for the closing summary
    int lines_started  = 0;
    int steps_sent     = 0;
    bit sender_steady  = 1'b0;
    int hold_requests  = 0;

    dda_line_rasterizer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    dda_line_checker pixel_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_data     (i_data),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_data    (o_data),
        .o_fail_count  (fail_total),
        .o_pending     (pixels_pending),
        .o_pixel_count (pixels_checked)
    );

    // 20 ns clock
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // watchdog: a hung handshake must not run forever
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("watchdog expired after %0d cycles", LIMIT_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

    // offer one word; valid stays up with the payload unchanged until taken.
    // the gap before it is random unless the sender is in a steady stretch
    task automatic offer_word(input dda_pkg::t_in_word w);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(MAX_GAP, 0);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // random filler so every payload bit toggles, even where it is ignored
    function automatic dda_pkg::t_in_word noise_word();
        logic [63:0]       r;
        dda_pkg::t_in_word w;
        r = {$urandom, $urandom};
        w = r[$bits(dda_pkg::t_in_word)-1:0];
        return w;
    endfunction

    task automatic start_line(input int xs, input int ys, input int xe, input int ye,
                              input int colour);
        dda_pkg::t_in_word w;
        w           = noise_word();
        w.opcode    = dda_pkg::OPC_START;
        w.x_start   = dda_pkg::COORD_BITS'(xs);
        w.y_start   = dda_pkg::COORD_BITS'(ys);
        w.x_end     = dda_pkg::COORD_BITS'(xe);
        w.y_end     = dda_pkg::COORD_BITS'(ye);
        w.colour_in = dda_pkg::COLOUR_BITS'(colour);
        lines_started++;
        offer_word(w);
    endtask

    task automatic step_words(input int count);
        dda_pkg::t_in_word w;
        repeat (count) begin
            w        = noise_word();
            w.opcode = dda_pkg::OPC_STEP;
            steps_sent++;
            offer_word(w);
        end
    endtask

    // endpoint at the given distance, direction random where both fit
    function automatic int nudge(int base, int span);
        if (base + span > COORD_MAX || (base - span >= 0 && $urandom_range(1, 0) == 1)) begin
            return base - span;
        end
        return base + span;
    endfunction

    // random line, either local (within reach) or spanning the whole plane;
    // gives back the number of step words that finish it
    task automatic random_line(input int reach, input bit full_plane, output int steps);
        int xs, ys, xe, ye, dx, dy;
        xs = $urandom_range(COORD_MAX, 0);
        ys = $urandom_range(COORD_MAX, 0);
        if (full_plane) begin
            xe = $urandom_range(COORD_MAX, 0);
            ye = $urandom_range(COORD_MAX, 0);
        end else begin
            xe = nudge(xs, $urandom_range(reach, 0));
            ye = nudge(ys, $urandom_range(reach, 0));
        end
        dx    = (xe > xs) ? xe - xs : xs - xe;
        dy    = (ye > ys) ? ye - ys : ys - ye;
        steps = (dx > dy) ? dx : dy;
        start_line(xs, ys, xe, ye, $urandom_range(15, 0));
    endtask

    // pixel sink: random stall before each word, steady stretches with none,
    // and one long hold-off on request so the block backs up into its input
    initial begin : pixel_sink
        int  stall;
        int  holds_served;
        bit  steady;
        holds_served = 0;
        steady       = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(MAX_GAP, 0);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                stall        = stall + HOLD_CYCLES;
            end
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if ($urandom_range(31, 0) == 0) begin
                steady = !steady;
            end
        end
    end

    initial begin : stimulus
        int steps;
        int count;
        int pick;
        int counted;
        int waited;
        bit pressure_done;
        counted       = 0;
        pressure_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---------------- directed part ----------------
        // step before any line: nothing comes out
        step_words(1);
        // zero-length lines at both corners, colour extremes
        start_line(0, 0, 0, 0, 0);
        step_words(1);
        start_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 15);
        // full diagonal, a few pixels, then dropped by a new start
        start_line(0, 0, COORD_MAX, COORD_MAX, 15);
        step_words(3);
        // anti-diagonal: x falls while y rises
        start_line(COORD_MAX, 0, 0, COORD_MAX, 5);
        step_words(2);
        // short horizontal line run to its end, plus one step past it
        start_line(0, 0, 3, 0, 10);
        step_words(4);
        // vertical line going down
        start_line(7, 9, 7, 6, 3);
        step_words(3);
        // y slope of one half: exercises round half up
        start_line(0, 0, 2, 1, 12);
        step_words(2);

        // ---------------- random part ----------------
        while (counted < RANDOM_WORDS) begin
            if ($urandom_range(3, 0) == 0) begin
                sender_steady = !sender_steady;
            end
            pick = $urandom_range(99, 0);
            if (!pressure_done && counted > RANDOM_WORDS / 2) begin
                // long line with the sink held off: output backs up, input stalls
                pressure_done = 1'b1;
                sender_steady = 1'b1;
                hold_requests++;
                start_line(100, 200, 100 + PRESSURE_LEN, 200 + PRESSURE_LEN / 3, 9);
                step_words(PRESSURE_LEN);
                counted += PRESSURE_LEN + 1;
            end else if (pick < 80) begin
                // well-formed line: mostly short, sometimes a few hundred pixels
                random_line(($urandom_range(19, 0) == 0) ? 400 : 24, 1'b0, steps);
                count = steps;
                pick  = $urandom_range(9, 0);
                if (pick == 0 && steps > 0) begin
                    // abandoned part way, the next start drops it
                    count = $urandom_range(steps - 1, 0);
                end
                step_words(count);
                counted += count + 1;
                if (pick == 1) begin
                    // steps past the end are ignored
                    step_words($urandom_range(3, 1));
                end
            end else if (pick < 90) begin
                // endpoints anywhere; only the first pixels are walked
                random_line(0, 1'b1, steps);
                count = $urandom_range((steps < 30) ? steps : 30, 0);
                step_words(count);
                counted += count + 1;
            end else begin
                // stray steps, usually with no line in progress
                step_words($urandom_range(3, 1));
            end
        end

        // ---------------- drain ----------------
        i_valid <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (pixels_pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pixels_pending != 0) begin
            $display("%0d expected pixels never came out", pixels_pending);
        end
        $display("run covered %0d lines (zero-length, diagonal, axis, abandoned) and %0d steps",
                 lines_started, steps_sent);
        $display("%0d pixels compared with the predicted line, %0d field mismatches",
                 pixels_checked, fail_total);
        if (fail_total == 0 && pixels_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/dda_pkg.sv
design/dda_divider.sv
design/dda_line_rasterizer.sv
tb/sv/dda_line_checker.sv
tb/sv/dda_line_rasterizer_test.sv
